// File: hw/rtl/gsc_pkg.sv
// Shared constants and control types for the strong connectivity checker.
`default_nettype none

package gsc_pkg;

   localparam int MaxNodesDefault  = 64;
   localparam int MaxGroupsDefault = 16;
   localparam logic [6:0] NodeCountReset = 7'd64;

   localparam logic [1:0] ACT_CLEAR     = 2'd0;
   localparam logic [1:0] ACT_SET_GROUP = 2'd1;
   localparam logic [1:0] ACT_ADD_EDGE  = 2'd2;
   localparam logic [1:0] ACT_RUN_CHECK = 2'd3;

   typedef struct packed {
      logic clear;
      logic set_group;
      logic edge_read;
      logic edge_write;
      logic chk_init;
      logic seed;
      logic switch_mode;
      logic pick;
      logic merge;
      logic eval;
      logic next;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic pending_empty;
      logic mode_group;
      logic finish;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/gsc_ctrl.sv
// Sequencer for graph loading and the reachability sweep.
`default_nettype none

module gsc_ctrl import gsc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [1:0] req_action,
   input  status_type      sts,
   output cmd_type         cmd,
   output logic            busy,
   output logic            rsp_valid
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EDGE  = 3'd1;
   localparam logic [2:0] ST_SEED  = 3'd2;
   localparam logic [2:0] ST_PICK  = 3'd3;
   localparam logic [2:0] ST_MERGE = 3'd4;
   localparam logic [2:0] ST_EVAL  = 3'd5;
   localparam logic [2:0] ST_NEXT  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_CLEAR:     cmd.clear = 1'b1;
                  ACT_SET_GROUP: cmd.set_group = 1'b1;
                  ACT_ADD_EDGE: begin
                     cmd.edge_read = 1'b1;
                     state_in      = ST_EDGE;
                  end
                  default: begin
                     cmd.chk_init = 1'b1;
                     state_in     = ST_SEED;
                  end
               endcase
            end
         end
         ST_EDGE: begin
            cmd.edge_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SEED: begin
            if (sts.skip) begin
               if (sts.mode_group) state_in = ST_NEXT;
               else cmd.switch_mode = 1'b1;
            end else begin
               cmd.seed = 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (sts.pending_empty) begin
               state_in = ST_EVAL;
            end else begin
               cmd.pick = 1'b1;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_PICK;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.mode_group) begin
               state_in = ST_NEXT;
            end else begin
               cmd.switch_mode = 1'b1;
               state_in        = ST_SEED;
            end
         end
         ST_NEXT: begin
            if (sts.finish) begin
               state_in = ST_DONE;
            end else begin
               cmd.next = 1'b1;
               state_in = ST_SEED;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/gsc_datapath.sv
// Adjacency memory, group tags, search sets and verdict registers.
`default_nettype none

module gsc_datapath import gsc_pkg::*; #(
   parameter int MAX_NODES  = MaxNodesDefault,
   parameter int MAX_GROUPS = MaxGroupsDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data,
   input  wire logic [5:0] req_source_node,
   input  wire logic [5:0] req_target_node,
   input  wire logic [3:0] req_group_id,
   input  cmd_type         cmd,
   output status_type      sts,
   output logic            rsp_graph_connected,
   output logic [5:0]      rsp_failing_node,
   output logic            rsp_groups_connected,
   output logic [3:0]      rsp_failing_group
);

   localparam int IW = $clog2(MAX_NODES);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int CW = (NW > 7) ? NW : 7;

   logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 rdv_ff;
   logic [MAX_NODES-1:0] rv_ff;
   logic [GW-1:0]        grp_ff [MAX_NODES];

   logic [6:0]           node_count_ff;
   logic [IW-1:0]        edge_src_ff;
   logic [IW-1:0]        edge_dst_ff;
   logic                 edge_ok_ff;

   logic [MAX_NODES-1:0] visited_ff, pending_ff;
   logic [IW-1:0]        start_ff;
   logic                 mode_ff;
   logic [GW-1:0]        g_ff;
   logic                 gc_ff, grc_ff;
   logic [IW-1:0]        fnode_ff;
   logic [GW-1:0]        fgroup_ff;

   logic [CW-1:0]        cnt_w;
   logic [NW-1:0]        n_w;
   logic [MAX_NODES-1:0] use_mask, grp_mask, low_bit, new_bits, scope, start_bit;
   logic [IW-1:0]        low_idx, rd_addr;
   logic                 rd_en, miss;

   // Clamp node count to the range 1..MAX_NODES.
   always_comb begin
      cnt_w = CW'(node_count_ff);
      if (cnt_w == '0) n_w = NW'(1);
      else if (cnt_w > CW'(MAX_NODES)) n_w = NW'(MAX_NODES);
      else n_w = NW'(cnt_w);
   end

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         use_mask[i] = (NW'(i) < n_w);
         grp_mask[i] = (grp_ff[i] == g_ff);
      end
   end

   // Lowest pending node, then one-hot to index.
   assign low_bit = pending_ff & (~pending_ff + 1'b1);
   always_comb begin
      low_idx = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (low_bit[i]) low_idx = low_idx | IW'(i);
      end
   end

   assign start_bit = MAX_NODES'(1) << start_ff;
   assign scope     = mode_ff ? (use_mask & grp_mask) : use_mask;
   assign new_bits  = (rdv_ff ? rd_data_ff : '0) & scope & ~visited_ff;
   assign miss      = |(scope & ~visited_ff);

   assign rd_en   = cmd.edge_read | cmd.pick;
   assign rd_addr = cmd.edge_read ? IW'(req_source_node) : low_idx;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= adj_mem[rd_addr];
         rdv_ff     <= rv_ff[rd_addr];
      end
      if (cmd.edge_write && edge_ok_ff) begin
         adj_mem[edge_src_ff] <= (rdv_ff ? rd_data_ff : '0) |
                                 (MAX_NODES'(1) << edge_dst_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_read) begin
         edge_src_ff <= IW'(req_source_node);
         edge_dst_ff <= IW'(req_target_node);
         edge_ok_ff  <= (32'(req_source_node) < 32'(MAX_NODES)) &&
                        (32'(req_target_node) < 32'(MAX_NODES));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         rv_ff <= '0;
         for (int i = 0; i < MAX_NODES; i++) grp_ff[i] <= '0;
      end else begin
         if (cmd.edge_write && edge_ok_ff) rv_ff[edge_src_ff] <= 1'b1;
         if (cmd.set_group && (32'(req_source_node) < 32'(MAX_NODES)) &&
             (32'(req_group_id) < 32'(MAX_GROUPS))) begin
            grp_ff[IW'(req_source_node)] <= GW'(req_group_id);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= NodeCountReset;
      else if (csr_wr_en) node_count_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         pending_ff <= '0;
         start_ff   <= '0;
         mode_ff    <= 1'b0;
         gc_ff      <= 1'b1;
         grc_ff     <= 1'b1;
         fnode_ff   <= '0;
         fgroup_ff  <= '0;
         g_ff       <= '0;
      end else begin
         if (cmd.chk_init) begin
            start_ff  <= '0;
            mode_ff   <= 1'b0;
            gc_ff     <= 1'b1;
            grc_ff    <= 1'b1;
            fnode_ff  <= '0;
            fgroup_ff <= '0;
         end
         if (cmd.seed) begin
            visited_ff <= start_bit;
            pending_ff <= start_bit;
            g_ff       <= grp_ff[start_ff];
         end
         if (cmd.pick) pending_ff <= pending_ff & ~low_bit;
         if (cmd.merge) begin
            visited_ff <= visited_ff | new_bits;
            pending_ff <= pending_ff | new_bits;
         end
         if (cmd.eval && miss) begin
            if (mode_ff) begin
               grc_ff    <= 1'b0;
               fgroup_ff <= grp_ff[start_ff];
            end else begin
               gc_ff    <= 1'b0;
               fnode_ff <= start_ff;
            end
         end
         if (cmd.switch_mode) mode_ff <= 1'b1;
         if (cmd.next) begin
            start_ff <= start_ff + 1'b1;
            mode_ff  <= 1'b0;
         end
      end
   end

   assign sts.skip          = mode_ff ? !grc_ff : !gc_ff;
   assign sts.pending_empty = (pending_ff == '0);
   assign sts.mode_group    = mode_ff;
   assign sts.finish        = (!gc_ff && !grc_ff) || (NW'(start_ff) == n_w - NW'(1));

   assign rsp_graph_connected  = gc_ff;
   assign rsp_failing_node     = 6'(fnode_ff);
   assign rsp_groups_connected = grc_ff;
   assign rsp_failing_group    = 4'(fgroup_ff);

endmodule

`default_nettype wire

// File: hw/rtl/graph_strong_connectivity_check.sv
// Top level of the directed graph strong connectivity checker.
//
//   channel   ports                        handshake
//   request   req_action/source/target/id  start, busy
//   response  rsp_graph_connected .. group rsp_valid strobe, one cycle
//   config    csr_wr_data                  csr_wr_en
//
// Clear and set-group transactions never raise busy; add-edge reads the
// adjacency row, then writes it through the single memory port. A check
// runs up to two searches per start node, one over all nodes and one
// within the start node's group; each node expanded is picked with an
// adjacency row read, then merged. Synchronous reset clears all edges,
// tags and control. The response cannot be stalled.
`default_nettype none

module graph_strong_connectivity_check import gsc_pkg::*; #(
   parameter int MAX_NODES  = MaxNodesDefault,
   parameter int MAX_GROUPS = MaxGroupsDefault
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_action,
   input  wire logic [5:0] req_source_node,
   input  wire logic [5:0] req_target_node,
   input  wire logic [3:0] req_group_id,
   output logic            rsp_valid,
   output logic            rsp_graph_connected,
   output logic [5:0]      rsp_failing_node,
   output logic            rsp_groups_connected,
   output logic [3:0]      rsp_failing_group,
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data
);

   cmd_type    cmd;
   status_type sts;

   gsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   gsc_datapath #(
      .MAX_NODES  (MAX_NODES),
      .MAX_GROUPS (MAX_GROUPS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_source_node      (req_source_node),
      .req_target_node      (req_target_node),
      .req_group_id         (req_group_id),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_graph_connected  (rsp_graph_connected),
      .rsp_failing_node     (rsp_failing_node),
      .rsp_groups_connected (rsp_groups_connected),
      .rsp_failing_group    (rsp_failing_group)
   );

endmodule

`default_nettype wire

// File: hw/rtl/gsc_checker.sv
// Port-level assertions for the connectivity checker, bound to the top level.
`default_nettype none

module gsc_checker import gsc_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic       rsp_graph_connected,
   input wire logic [5:0] rsp_failing_node,
   input wire logic       rsp_groups_connected,
   input wire logic [3:0] rsp_failing_group
);

   // A check transaction keeps the block busy on the next cycle.
   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_RUN_CHECK) |=> busy)
      else $error("check transaction did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   a_node_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_graph_connected) |-> (rsp_failing_node == 6'd0))
      else $error("failing node nonzero on a connected graph");

   a_group_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_groups_connected) |-> (rsp_failing_group == 4'd0))
      else $error("failing group nonzero on connected groups");

endmodule

bind graph_strong_connectivity_check gsc_checker u_gsc_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_action           (req_action),
   .rsp_valid            (rsp_valid),
   .rsp_graph_connected  (rsp_graph_connected),
   .rsp_failing_node     (rsp_failing_node),
   .rsp_groups_connected (rsp_groups_connected),
   .rsp_failing_group    (rsp_failing_group)
);

`default_nettype wire
